// ===== hw/rtl/rpi_pkg.sv =====
// Shared types and constants for the ray/plane intersection block.
package rpi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int NORM_W = 16;
  localparam int EPS_W = 16;
  localparam int MAG_W = 50;
  localparam int REM_W = MAG_W + 1;
  localparam int QUO_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 3'd4;

  localparam logic signed [NORM_W-1:0] NORMAL_Z_RST = 16'sd16384;
  localparam logic [EPS_W-1:0] EPSILON_RST = 16'd1;

  typedef struct packed {
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
    logic signed [FIELD_W-1:0] d;
    logic [EPS_W-1:0]          eps;
  } cfg_t;

  // Classified ray, waiting for the divider.
  typedef struct packed {
    logic             miss;
    logic             sat;
    logic             flip;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } job_t;

  typedef struct packed {
    logic             miss;
    logic             sat;
    logic             flip;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] q;
    logic [MAG_W-1:0] b;
  } div_t;

endpackage

// ===== hw/rtl/rpi_ray_if.sv =====
// Ray input channel.
interface rpi_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;
  modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

// ===== hw/rtl/rpi_hit_if.sv =====
// Intersection result channel.
interface rpi_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] distance;
  logic        normal_flipped;
  modport source(output valid, hit, distance, normal_flipped, input ready);
  modport sink(input valid, hit, distance, normal_flipped, output ready);
endinterface

// ===== hw/rtl/rpi_front.sv =====
// Front end: dot products and hit/miss classification.
module rpi_front #(
  parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rpi_ray_if.sink       ray,
  input  rpi_pkg::cfg_t cfg,
  input  logic          full,
  output logic          push,
  output rpi_pkg::job_t job
);
  localparam int CwEff = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  logic signed [31:0] sx, sy, sz, dx, dy, dz, dd;
  logic v1, v2, v3, ce;
  logic signed [47:0] px, py, pz, qx, qy, qz;
  logic signed [45:0] doff;
  logic signed [50:0] n;
  logic signed [49:0] den;
  logic [50:0] amag;
  logic [49:0] bmag;
  logic [29:0] eps30;
  logic neg;

  always_comb begin
    sx = ray.origin_x; sy = ray.origin_y; sz = ray.origin_z;
    dx = ray.dir_x; dy = ray.dir_y; dz = ray.dir_z;
    dd = cfg.d;
    for (int i = CwEff; i < 32; i++) begin
      sx[i] = ray.origin_x[CwEff-1]; sy[i] = ray.origin_y[CwEff-1];
      sz[i] = ray.origin_z[CwEff-1]; dx[i] = ray.dir_x[CwEff-1];
      dy[i] = ray.dir_y[CwEff-1]; dz[i] = ray.dir_z[CwEff-1];
      dd[i] = cfg.d[CwEff-1];
    end
  end

  assign ce = !(v3 && full);
  assign ray.ready = ce;
  assign push = v3 && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= ray.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Q2.14 x Q16.16 products land at Q.30; offset moved up by 14
  always_ff @(posedge clk) begin
    if (ce) begin
      px <= cfg.nx * sx;
      py <= cfg.ny * sy;
      pz <= cfg.nz * sz;
      qx <= cfg.nx * dx;
      qy <= cfg.ny * dy;
      qz <= cfg.nz * dz;
      doff <= $signed({dd, 14'b0});
      n <= 51'(px) + 51'(py) + 51'(pz) + 51'(doff);
      den <= 50'(qx) + 50'(qy) + 50'(qz);
    end
  end

  always_comb begin
    amag = n[50] ? -n : n;
    bmag = den[49] ? -den : den;
    eps30 = {cfg.eps, 14'b0};
    // t = -n/den is negative when n and den share a sign
    neg = (n != 51'sd0) && ((n > 51'sd0) != den[49]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      job.miss <= (den == 50'sd0) || (bmag < {20'b0, eps30}) || neg;
      job.sat <= {15'b0, amag[49:0]} >= {bmag, 15'b0};
      job.flip <= !(n > $signed({21'b0, eps30}));
      job.a <= amag[49:0];
      job.b <= bmag;
    end
  end
endmodule

// ===== hw/rtl/rpi_queue.sv =====
// Short queue between front end and divider.
module rpi_queue #(
  parameter int DEPTH = rpi_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpi_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output rpi_pkg::job_t dout,
  output logic          empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rpi_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end
endmodule

// ===== hw/rtl/rpi_back.sv =====
// Back end: pipelined bit-per-stage divider and result register.
module rpi_back (
  input  logic          clk,
  input  logic          rst,
  input  rpi_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  input  rpi_pkg::cfg_t cfg,
  rpi_hit_if.source     res
);
  localparam int QW = rpi_pkg::QUO_W;
  localparam int RW = rpi_pkg::REM_W;
  localparam int MW = rpi_pkg::MAG_W;

  rpi_pkg::div_t st [QW+1];
  logic vld [QW+1];
  logic ce;
  logic [QW-1:0] qf;
  logic hit_c;

  assign ce = !res.valid || res.ready;
  assign pop = ce && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QW; j++) vld[j] <= 1'b0;
    end else if (ce) begin
      vld[0] <= pop;
      for (int j = 1; j <= QW; j++) vld[j] <= vld[j-1];
    end
  end

  // dividend is a * 2^16; its top part seeds the remainder
  always_ff @(posedge clk) begin
    if (ce) begin
      st[0].miss <= job.miss;
      st[0].sat <= job.sat;
      st[0].flip <= job.flip;
      st[0].rem <= RW'(job.a[MW-1:15]);
      st[0].low <= {job.a[14:0], 16'b0};
      st[0].q <= '0;
      st[0].b <= job.b;
      for (int j = 1; j <= QW; j++) begin
        logic [RW-1:0] t;
        logic ge;
        t = {st[j-1].rem[RW-2:0], st[j-1].low[QW-1]};
        ge = t >= {1'b0, st[j-1].b};
        st[j].miss <= st[j-1].miss;
        st[j].sat <= st[j-1].sat;
        st[j].flip <= st[j-1].flip;
        st[j].rem <= ge ? t - {1'b0, st[j-1].b} : t;
        st[j].low <= {st[j-1].low[QW-2:0], 1'b0};
        st[j].q <= {st[j-1].q[QW-2:0], ge};
        st[j].b <= st[j-1].b;
      end
    end
  end

  always_comb begin
    qf = st[QW].sat ? '1 : st[QW].q;
    hit_c = !st[QW].miss && (qf >= QW'(cfg.eps));
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (ce) res.valid <= vld[QW];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res.hit <= hit_c;
      res.distance <= hit_c ? qf : '0;
      res.normal_flipped <= hit_c && st[QW].flip;
    end
  end
endmodule

// ===== hw/rtl/ray_plane_intersection.sv =====
// Ray/plane intersection top level: config registers, front end, queue, divider.
//
//   channel | dir | handshake        | beat
//   ray     | in  | valid/ready      | origin_x..z, dir_x..z
//   res     | out | valid/ready      | hit, distance, normal_flipped
//   cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// One ray per cycle sustained while results are taken; the path is 3 front
// stages, queue, 32 divider stages, output register; the divider is a 31-bit
// one-bit-per-stage divider.
// Reset (rst, synchronous) empties all stages and loads register defaults.
// A stalled result holds the divider; the queue keeps the front end moving
// until it fills, then ray.ready drops.
module ray_plane_intersection #(
  parameter int COORD_WIDTH = rpi_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rpi_ray_if.sink                         ray,
  rpi_hit_if.source                       res,
  input  logic                            cfg_we,
  input  logic [rpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpi_pkg::FIELD_W-1:0]     cfg_data
);
  rpi_pkg::cfg_t cfg;
  rpi_pkg::job_t fj, qj;
  logic push, full, pop, empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nx <= '0;
      cfg.ny <= '0;
      cfg.nz <= rpi_pkg::NORMAL_Z_RST;
      cfg.d <= '0;
      cfg.eps <= rpi_pkg::EPSILON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rpi_pkg::REG_NORMAL_X: cfg.nx <= cfg_data[15:0];
        rpi_pkg::REG_NORMAL_Y: cfg.ny <= cfg_data[15:0];
        rpi_pkg::REG_NORMAL_Z: cfg.nz <= cfg_data[15:0];
        rpi_pkg::REG_OFFSET:   cfg.d <= cfg_data;
        rpi_pkg::REG_EPSILON:  cfg.eps <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rpi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .ray(ray), .cfg(cfg), .full(full), .push(push), .job(fj)
  );

  rpi_queue #(.DEPTH(rpi_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(fj), .full(full),
    .pop(pop), .dout(qj), .empty(empty)
  );

  rpi_back u_back (
    .clk(clk), .rst(rst), .job(qj), .empty(empty), .pop(pop), .cfg(cfg), .res(res)
  );
endmodule

// ===== hw/rtl/rpi_checker.sv =====
// Port-level checks for the intersection block, bound to the top level.
module rpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [30:0] distance,
  input logic        normal_flipped
);
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0) else $error("result with no ray pending");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid right after reset");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (distance == 31'd0 && !normal_flipped))
    else $error("miss carries distance or flip");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hit) && $stable(distance)))
    else $error("stalled result changed");
endmodule

bind ray_plane_intersection rpi_checker u_rpi_checker (
  .clk(clk), .rst(rst), .in_valid(ray.valid), .in_ready(ray.ready),
  .out_valid(res.valid), .out_ready(res.ready), .hit(res.hit),
  .distance(res.distance), .normal_flipped(res.normal_flipped)
);
